// File: src/hpl_pkg.sv
// ----------------------------------------------------------------------------
// hpl_pkg : shared types, constants and tables for head pose estimation
// Holds the pose landmark index list, the coefficient table and the
// state encoding of the pose sequencer.
// ----------------------------------------------------------------------------
package hpl_pkg;

    localparam int POSE_POINTS    = 7;
    localparam int LANDMARK_COUNT = 68;
    localparam int VEC_LEN        = 2 * POSE_POINTS + 1;
    localparam int PT_W           = $clog2(POSE_POINTS);
    localparam int VEC_W          = $clog2(VEC_LEN);
    localparam int COORD_W        = 16;
    localparam int SUM_W          = COORD_W + $clog2(POSE_POINTS + 1);
    localparam int COEF_W         = 18;
    localparam int NUM_W          = 40;   // |P*v - S| * 4096 fits signed 40
    localparam int DEN_W          = SUM_W;
    localparam int QUO_W          = 32;   // doubled quotient range before saturation
    localparam int ACC_W          = 40;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SCAN_REQ,
        ST_SCAN,
        ST_NORM_REQ,
        ST_NORM_RD,
        ST_DIV,
        ST_MAC,
        ST_CLEAR,
        ST_OUT
    } seq_state_t;

    typedef struct packed {
        logic              wr_en;
        logic [PT_W-1:0]   wr_addr;
        logic [2*COORD_W-1:0] wr_data;
        logic [PT_W-1:0]   rd_addr;
    } pt_mem_ctl_t;

    // Slot of a landmark index in the pose list; POSE_POINTS when absent.
    function automatic logic [PT_W:0] pose_slot(input logic [6:0] idx);
        logic [PT_W:0] slot;
        slot = (PT_W+1)'(POSE_POINTS);
        unique case (idx)
            7'd27:   slot = (PT_W+1)'(0);
            7'd29:   slot = (PT_W+1)'(1);
            7'd33:   slot = (PT_W+1)'(2);
            7'd31:   slot = (PT_W+1)'(3);
            7'd65:   slot = (PT_W+1)'(4);
            7'd46:   slot = (PT_W+1)'(5);
            7'd52:   slot = (PT_W+1)'(6);
            default: slot = (PT_W+1)'(POSE_POINTS);
        endcase
        return slot;
    endfunction

    // Trained coefficients, row-major, Q8.10.
    function automatic logic signed [COEF_W-1:0] coef(input logic [VEC_W-1:0] row,
                                                      input logic [1:0] col);
        logic signed [COEF_W-1:0] c [0:2];
        c[0] = '0; c[1] = '0; c[2] = '0;
        unique case (row)
            4'd0:  begin c[0] =  18'sd143;   c[1] =  18'sd28060;  c[2] =  18'sd7195;  end
            4'd1:  begin c[0] = -18'sd2542;  c[1] =  18'sd9824;   c[2] =  18'sd6182;  end
            4'd2:  begin c[0] =  18'sd1305;  c[1] =  18'sd10731;  c[2] =  18'sd6357;  end
            4'd3:  begin c[0] =  18'sd1202;  c[1] =  18'sd29889;  c[2] =  18'sd1718;  end
            4'd4:  begin c[0] =  18'sd314;   c[1] = -18'sd106324; c[2] =  18'sd5798;  end
            4'd5:  begin c[0] =  18'sd4902;  c[1] =  18'sd18302;  c[2] = -18'sd15731; end
            4'd6:  begin c[0] = -18'sd5325;  c[1] =  18'sd9518;   c[2] = -18'sd11519; end
            4'd7:  begin c[0] = -18'sd25774; c[1] =  18'sd11126;  c[2] = -18'sd30195; end
            4'd8:  begin c[0] = -18'sd5761;  c[1] =  18'sd9305;   c[2] = -18'sd12389; end
            4'd9:  begin c[0] = -18'sd5322;  c[1] = -18'sd8451;   c[2] =  18'sd13718; end
            4'd10: begin c[0] = -18'sd24232; c[1] = -18'sd13450;  c[2] =  18'sd30139; end
            4'd11: begin c[0] =  18'sd68853; c[1] =  18'sd683;    c[2] =  18'sd1887;  end
            4'd12: begin c[0] = -18'sd2900;  c[1] =  18'sd4673;   c[2] = -18'sd16266; end
            4'd13: begin c[0] = -18'sd4863;  c[1] = -18'sd3886;   c[2] =  18'sd13106; end
            4'd14: begin c[0] = -18'sd16486; c[1] =  18'sd1507;   c[2] =  18'sd4136;  end
            default: begin c[0] = '0; c[1] = '0; c[2] = '0; end
        endcase
        unique case (col)
            2'd0:    return c[0];
            2'd1:    return c[1];
            default: return c[2];
        endcase
    endfunction

endpackage

// File: src/hpl_ram.sv
// ----------------------------------------------------------------------------
// hpl_ram : generic single-port-write, single-read RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module hpl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: src/hpl_div.sv
// ----------------------------------------------------------------------------
// hpl_div : iterative signed divider with round half away from zero
// Restoring division one quotient bit per cycle on magnitudes, then the
// sign and saturation to signed 16 bits.
// ----------------------------------------------------------------------------
module hpl_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [hpl_pkg::NUM_W-1:0]  num,
    input  logic [hpl_pkg::DEN_W-1:0]         den,
    output logic                              done,
    output logic signed [15:0]                quo
);

    localparam int QW = hpl_pkg::QUO_W;
    localparam int RW = hpl_pkg::DEN_W + 1;

    logic [hpl_pkg::NUM_W-1:0] dvd_reg, dvd_next;
    logic [RW-1:0]             rem_reg, rem_next;
    logic [QW-1:0]             q_reg, q_next;
    logic [hpl_pkg::DEN_W-1:0] den_reg, den_next;
    logic                      neg_reg, neg_next;
    logic [5:0]                cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [RW-1:0]             trial;
    logic [hpl_pkg::NUM_W-1:0] mag;
    logic [QW:0]               rounded;
    logic signed [QW+1:0]      signed_q;

    // magnitude, doubled so the half-divisor rounding becomes a last bit
    always_comb
    begin
        mag = num[hpl_pkg::NUM_W-1] ? hpl_pkg::NUM_W'(-num) : hpl_pkg::NUM_W'(num);
        trial = {rem_reg[RW-2:0], dvd_reg[hpl_pkg::NUM_W-1]};
    end

    // one quotient bit per cycle over doubled numerator: q2 = floor(2|n|/d)
    always_comb
    begin
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        q_next   = q_reg;
        den_next = den_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = busy_reg && (cnt_reg == 6'd1);
        if (start)
        begin
            dvd_next  = mag;
            rem_next  = '0;
            q_next    = '0;
            den_next  = den;
            neg_next  = num[hpl_pkg::NUM_W-1];
            cnt_next  = 6'(hpl_pkg::NUM_W + 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[hpl_pkg::NUM_W-2:0], 1'b0};
            if (trial >= RW'(den_reg))
            begin
                rem_next = trial - RW'(den_reg);
                q_next   = {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    // hold iteration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // (2q'+1)/2 floor gives round half up on magnitude; saturate
    always_comb
    begin
        rounded  = ({1'b0, q_reg} + (QW+1)'(1)) >> 1;
        signed_q = neg_reg ? -$signed({1'b0, rounded}) : $signed({1'b0, rounded});
        if (signed_q > 32767)
            quo = 16'sd32767;
        else if (signed_q < -32768)
            quo = -16'sd32768;
        else
            quo = signed_q[15:0];
        done = done_reg;
    end

    // a start never arrives mid-division
    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> !start)
        else $error("divider restarted while busy");
    assert property (@(posedge clk) disable iff (!rst_n) start |=> busy_reg)
        else $error("divider failed to start");
    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> den_reg != '0)
        else $error("division by zero");

endmodule

// File: src/hpl_seq.sv
// ----------------------------------------------------------------------------
// hpl_seq : pose sequencer
// Captures pose landmarks into the point memory, then scans it for sums
// and y extremes, normalizes each coordinate and accumulates the three
// angle dot products unless the shape is degenerate, and finally clears the memory.
// ----------------------------------------------------------------------------
module hpl_seq (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [6:0]  landmark_index,
    input  logic [15:0] coord_x,
    input  logic [15:0] coord_y,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [15:0] pitch,
    output logic signed [15:0] yaw,
    output logic signed [15:0] roll,
    output logic        degenerate,
    output hpl_pkg::pt_mem_ctl_t mem_ctl,
    input  logic [2*hpl_pkg::COORD_W-1:0] mem_rd_data,
    output logic        div_start,
    output logic signed [hpl_pkg::NUM_W-1:0] div_num,
    output logic [hpl_pkg::DEN_W-1:0] div_den,
    input  logic        div_done,
    input  logic signed [15:0] div_quo
);

    localparam int P  = hpl_pkg::POSE_POINTS;
    localparam int PW = hpl_pkg::PT_W;
    localparam int VW = hpl_pkg::VEC_W;
    localparam int SW = hpl_pkg::SUM_W;
    localparam int AW = hpl_pkg::ACC_W;

    hpl_pkg::seq_state_t state_reg, state_next;
    logic [P-1:0]    seen_reg, seen_next;
    logic [PW:0]     ptr_reg, ptr_next;
    logic            axis_reg, axis_next;   // 0 = x, 1 = y
    logic [SW-1:0]   sx_reg, sx_next, sy_reg, sy_next;
    logic [15:0]     miny_reg, miny_next, maxy_reg, maxy_next;
    logic signed [15:0] nval_reg, nval_next;
    logic [1:0]      col_reg, col_next;
    logic signed [AW-1:0] acc_reg [0:2];
    logic signed [AW-1:0] acc_next [0:2];
    logic signed [16+hpl_pkg::COEF_W-1:0] prod_reg, prod_next;
    logic            prod_vld_reg, prod_vld_next;
    logic [1:0]      prod_col_reg, prod_col_next;
    logic [VW-1:0]   row_reg, row_next;
    logic            ovalid_reg, ovalid_next;
    logic signed [15:0] pitch_reg, yaw_reg, roll_reg;
    logic signed [15:0] pitch_next, yaw_next, roll_next;
    logic            degen_reg, degen_next;
    logic [PW-1:0]   rd_addr_reg;

    logic [PW:0]     slot;
    logic            accept;
    logic            rd_seen;
    logic [15:0]     rd_x, rd_y;
    logic [15:0]     span;
    logic signed [SW+3:0] pv;
    logic signed [15:0] ang [0:2];

    // a pose point not captured in this shape reads as (0, 0)
    assign slot    = hpl_pkg::pose_slot(landmark_index);
    assign accept  = in_valid && !in_stall;
    assign rd_seen = seen_reg[rd_addr_reg];
    assign rd_x    = rd_seen ? mem_rd_data[2*hpl_pkg::COORD_W-1:hpl_pkg::COORD_W] : '0;
    assign rd_y    = rd_seen ? mem_rd_data[hpl_pkg::COORD_W-1:0] : '0;
    assign span    = maxy_reg - miny_reg;

    // round Q.22 sum to Q9.7 half away from zero and saturate
    function automatic logic signed [15:0] to_angle(input logic signed [AW-1:0] a);
        logic [AW-1:0] mag;
        logic [AW-1:0] q;
        logic signed [AW:0] s;
        mag = a[AW-1] ? AW'(-a) : AW'(a);
        q   = (mag + AW'(16384)) >> 15;
        s   = a[AW-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        if (s > 32767)
            return 16'sd32767;
        else if (s < -32768)
            return -16'sd32768;
        else
            return s[15:0];
    endfunction

    always_comb
    begin
        ang[0] = to_angle(acc_reg[0]);
        ang[1] = to_angle(acc_reg[1]);
        ang[2] = to_angle(acc_reg[2]);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hpl_pkg::ST_LOAD:
                if (accept && last) state_next = hpl_pkg::ST_SCAN_REQ;
            hpl_pkg::ST_SCAN_REQ:
                state_next = hpl_pkg::ST_SCAN;
            hpl_pkg::ST_SCAN:
                if (ptr_reg == (PW+1)'(P - 1)) state_next = hpl_pkg::ST_NORM_REQ;
            hpl_pkg::ST_NORM_REQ:
                if (seen_reg == '0 || span == '0) state_next = hpl_pkg::ST_CLEAR;
                else state_next = hpl_pkg::ST_NORM_RD;
            hpl_pkg::ST_NORM_RD:
                state_next = hpl_pkg::ST_DIV;
            hpl_pkg::ST_DIV:
                if (div_done) state_next = hpl_pkg::ST_MAC;
            hpl_pkg::ST_MAC:
                if (col_reg == 2'd2)
                begin
                    if (row_reg == VW'(2 * P)) state_next = hpl_pkg::ST_CLEAR;
                    else if (row_reg == VW'(2 * P - 1)) state_next = hpl_pkg::ST_MAC;
                    else state_next = hpl_pkg::ST_NORM_RD;
                end
            hpl_pkg::ST_CLEAR:
                if (ptr_reg == (PW+1)'(P - 1) && !prod_vld_reg) state_next = hpl_pkg::ST_OUT;
            hpl_pkg::ST_OUT:
                if (!ovalid_reg) state_next = hpl_pkg::ST_LOAD;
            default:
                state_next = hpl_pkg::ST_LOAD;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        seen_next  = seen_reg;
        ptr_next   = ptr_reg;
        axis_next  = axis_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        miny_next  = miny_reg;
        maxy_next  = maxy_reg;
        nval_next  = nval_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        acc_next   = acc_reg;
        prod_next  = prod_reg;
        prod_vld_next = 1'b0;
        prod_col_next = col_reg;
        ovalid_next = ovalid_reg && out_stall;
        pitch_next = pitch_reg;
        yaw_next   = yaw_reg;
        roll_next  = roll_reg;
        degen_next = degen_reg;
        mem_ctl    = '0;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = (hpl_pkg::DEN_W)'(P) * span;
        in_stall   = (state_reg != hpl_pkg::ST_LOAD);
        pv         = '0;

        // accumulate a registered product
        if (prod_vld_reg)
        begin
            acc_next[prod_col_reg] = acc_reg[prod_col_reg] + AW'(prod_reg);
        end

        unique case (state_reg)
            hpl_pkg::ST_LOAD:
            begin
                if (accept && landmark_index < 7'(hpl_pkg::LANDMARK_COUNT)
                    && slot != (PW+1)'(P))
                begin
                    mem_ctl.wr_en   = 1'b1;
                    mem_ctl.wr_addr = slot[PW-1:0];
                    mem_ctl.wr_data = {coord_x, coord_y};
                    seen_next[slot[PW-1:0]] = 1'b1;
                end
                ptr_next = '0;
                sx_next  = '0;
                sy_next  = '0;
                acc_next[0] = '0;
                acc_next[1] = '0;
                acc_next[2] = '0;
            end
            hpl_pkg::ST_SCAN_REQ:
            begin
                mem_ctl.rd_addr = '0;
                ptr_next = '0;
            end
            hpl_pkg::ST_SCAN:
            begin
                mem_ctl.rd_addr = (ptr_reg == (PW+1)'(P - 1))
                                  ? '0 : PW'(ptr_reg + (PW+1)'(1));
                sx_next = sx_reg + SW'(rd_x);
                sy_next = sy_reg + SW'(rd_y);
                if (ptr_reg == '0 || rd_y < miny_reg) miny_next = rd_y;
                if (ptr_reg == '0 || rd_y > maxy_reg) maxy_next = rd_y;
                ptr_next = ptr_reg + (PW+1)'(1);
            end
            hpl_pkg::ST_NORM_REQ:
            begin
                ptr_next  = '0;
                axis_next = 1'b0;
                row_next  = '0;
                col_next  = '0;
                mem_ctl.rd_addr = '0;
            end
            hpl_pkg::ST_NORM_RD:
            begin
                mem_ctl.rd_addr = ptr_reg[PW-1:0];
                pv = $signed({4'b0, (SW)'(P) * SW'(axis_reg ? rd_y : rd_x)})
                     - $signed({4'b0, axis_reg ? sy_reg : sx_reg});
                div_num   = (hpl_pkg::NUM_W)'(pv) <<< 12;
                div_start = 1'b1;
            end
            hpl_pkg::ST_DIV:
            begin
                mem_ctl.rd_addr = ptr_reg[PW-1:0];
                if (div_done)
                begin
                    nval_next = div_quo;
                    col_next  = '0;
                end
            end
            hpl_pkg::ST_MAC:
            begin
                prod_next = (row_reg == VW'(2 * P) ? 16'sd4096 : nval_reg)
                            * hpl_pkg::coef(row_reg, col_reg);
                prod_vld_next = 1'b1;
                prod_col_next = col_reg;
                col_next = col_reg + 2'd1;
                if (col_reg == 2'd2)
                begin
                    col_next = '0;
                    row_next = row_reg + VW'(1);
                    if (ptr_reg == (PW+1)'(P - 1))
                    begin
                        ptr_next  = '0;
                        axis_next = 1'b1;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + (PW+1)'(1);
                    end
                    if (row_reg == VW'(2 * P)) ptr_next = '0;
                end
                // fetch the point of the next row ahead of its normalize
                mem_ctl.rd_addr = ptr_next[PW-1:0];
            end
            hpl_pkg::ST_CLEAR:
            begin
                mem_ctl.wr_en   = 1'b1;
                mem_ctl.wr_addr = ptr_reg[PW-1:0];
                mem_ctl.wr_data = '0;
                if (ptr_reg != (PW+1)'(P - 1)) ptr_next = ptr_reg + (PW+1)'(1);
            end
            hpl_pkg::ST_OUT:
            begin
                if (!ovalid_reg)
                begin
                    // load result once the output register is free
                    ovalid_next = 1'b1;
                    degen_next  = (seen_reg == '0) || (span == '0);
                    pitch_next  = degen_next ? 16'sd0 : ang[0];
                    yaw_next    = degen_next ? 16'sd0 : ang[1];
                    roll_next   = degen_next ? 16'sd0 : ang[2];
                    seen_next   = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= hpl_pkg::ST_LOAD;
            seen_reg     <= '0;
            ptr_reg      <= '0;
            axis_reg     <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
            prod_vld_reg <= 1'b0;
            ovalid_reg   <= 1'b0;
            rd_addr_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            seen_reg     <= seen_next;
            ptr_reg      <= ptr_next;
            axis_reg     <= axis_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            prod_vld_reg <= prod_vld_next;
            ovalid_reg   <= ovalid_next;
            rd_addr_reg  <= mem_ctl.rd_addr;
        end
    end

    always_ff @(posedge clk)
    begin
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        miny_reg     <= miny_next;
        maxy_reg     <= maxy_next;
        nval_reg     <= nval_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        prod_col_reg <= prod_col_next;
        pitch_reg    <= pitch_next;
        yaw_reg      <= yaw_next;
        roll_reg     <= roll_next;
        degen_reg    <= degen_next;
    end

    assign out_valid  = ovalid_reg;
    assign pitch      = pitch_reg;
    assign yaw        = yaw_reg;
    assign roll       = roll_reg;
    assign degenerate = degen_reg;

    // no landmark accepted outside the load phase
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> state_reg == hpl_pkg::ST_LOAD)
        else $error("landmark accepted while computing");
    // a degenerate result carries zero angles
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && degenerate) |-> (pitch == 0 && yaw == 0 && roll == 0))
        else $error("degenerate result with nonzero angle");
    // divider is started only from the normalize read state
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> state_reg == hpl_pkg::ST_NORM_RD)
        else $error("stray divider start");
    // point-seen mask is empty when a new shape begins loading
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hpl_pkg::ST_OUT && !ovalid_reg) |=> seen_reg == '0)
        else $error("seen mask not cleared after shape");

endmodule

// File: src/head_pose_from_landmarks.sv
// Timing: after the last landmark the sequencer scans the points, normalizes the 14
//   coordinates one after another through the bit-serial divider and clears the
//   memory; a degenerate shape skips the normalizing. The result loads after that.
// Throughput: one landmark per cycle within a shape; input stalls from the last
//   landmark until the result is loaded, longer while an earlier result is held.
// Reset: rst_n asynchronous, active low; clears control state and the seen mask.
// ----------------------------------------------------------------------------
// head_pose_from_landmarks : head pose estimate from face landmarks
// Point memory, sequencer and shared divider.
// ----------------------------------------------------------------------------
module head_pose_from_landmarks (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [6:0]  landmark_index,
    input  logic [15:0] coord_x,
    input  logic [15:0] coord_y,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [15:0] pitch,
    output logic signed [15:0] yaw,
    output logic signed [15:0] roll,
    output logic        degenerate
);

    hpl_pkg::pt_mem_ctl_t mem_ctl;
    logic [2*hpl_pkg::COORD_W-1:0] mem_rd_data;
    logic        div_start, div_done;
    logic signed [hpl_pkg::NUM_W-1:0] div_num;
    logic [hpl_pkg::DEN_W-1:0] div_den;
    logic signed [15:0] div_quo;

    // captured pose points, x in the upper half
    hpl_ram #(.WIDTH(2 * hpl_pkg::COORD_W), .DEPTH(hpl_pkg::POSE_POINTS)) u_pts (
        .clk     (clk),
        .wr_en   (mem_ctl.wr_en),
        .wr_addr (mem_ctl.wr_addr),
        .wr_data (mem_ctl.wr_data),
        .rd_addr (mem_ctl.rd_addr),
        .rd_data (mem_rd_data)
    );

    hpl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    hpl_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .landmark_index (landmark_index),
        .coord_x        (coord_x),
        .coord_y        (coord_y),
        .last           (last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pitch          (pitch),
        .yaw            (yaw),
        .roll           (roll),
        .degenerate     (degenerate),
        .mem_ctl        (mem_ctl),
        .mem_rd_data    (mem_rd_data),
        .div_start      (div_start),
        .div_num        (div_num),
        .div_den        (div_den),
        .div_done       (div_done),
        .div_quo        (div_quo)
    );

endmodule

// File: dv/head_pose_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// head_pose_checker : transaction checker for head_pose_from_landmarks
// Watches the landmark and pose channels, predicts each pose result from the
// accepted landmarks and compares the result fields in order.
// ----------------------------------------------------------------------------
module head_pose_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [6:0]         landmark_index,
    input  logic [15:0]        coord_x,
    input  logic [15:0]        coord_y,
    input  logic               last,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [15:0] pitch,
    input  logic signed [15:0] yaw,
    input  logic signed [15:0] roll,
    input  logic               degenerate,
    output int                 fail_count,
    output int                 pending_poses,
    output int                 pose_count,
    output int                 degenerate_count
);

    localparam int POSE_POINTS    = hpl_pkg::POSE_POINTS;
    localparam int VEC_LEN        = hpl_pkg::VEC_LEN;
    localparam int LANDMARK_COUNT = hpl_pkg::LANDMARK_COUNT;

    typedef struct packed {
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic signed [15:0] roll;
        logic               degenerate;
    } pose_t;

    localparam int unsigned SLOT_INDEX [POSE_POINTS] = '{27, 29, 33, 31, 65, 46, 52};
    localparam longint WEIGHT [VEC_LEN*3] = '{
           143,  28060,   7195,   -2542,   9824,   6182,    1305,  10731,   6357,
          1202,  29889,   1718,     314, -106324,  5798,    4902,  18302, -15731,
         -5325,   9518, -11519,  -25774,  11126, -30195,   -5761,   9305, -12389,
         -5322,  -8451,  13718,  -24232, -13450,  30139,   68853,    683,   1887,
         -2900,   4673, -16266,   -4863,  -3886,  13106,  -16486,   1507,   4136};

    logic [15:0] shape_x [POSE_POINTS];
    logic [15:0] shape_y [POSE_POINTS];
    logic [POSE_POINTS-1:0] shape_seen;
    pose_t expected_poses [$];

    // Divide rounding half away from zero; den > 0.
    function automatic longint round_div(longint num, longint den);
        longint mag;
        mag = (num < 0) ? -num : num;
        mag = (mag + den / 2) / den;
        return (num < 0) ? -mag : mag;
    endfunction

    function automatic longint clip16(longint v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    function automatic pose_t estimate_pose();
        pose_t  p;
        longint sx, sy, lo, hi, den, acc;
        longint vec [VEC_LEN];
        p = '0;
        sx = 0; sy = 0; lo = 0; hi = 0;
        for (int i = 0; i < POSE_POINTS; i++)
        begin
            sx += shape_x[i];
            sy += shape_y[i];
            if (i == 0 || shape_y[i] < lo) lo = shape_y[i];
            if (i == 0 || shape_y[i] > hi) hi = shape_y[i];
        end
        if (shape_seen == '0 || hi == lo)
        begin
            p.degenerate = 1'b1;
            return p;
        end
        den = POSE_POINTS * (hi - lo);
        for (int i = 0; i < POSE_POINTS; i++)
        begin
            vec[i] = clip16(round_div((POSE_POINTS * longint'(shape_x[i]) - sx) * 4096, den));
            vec[i+POSE_POINTS] =
                clip16(round_div((POSE_POINTS * longint'(shape_y[i]) - sy) * 4096, den));
        end
        vec[2*POSE_POINTS] = 4096;
        for (int k = 0; k < 3; k++)
        begin
            acc = 0;
            for (int i = 0; i < VEC_LEN; i++)
                acc += vec[i] * WEIGHT[i*3+k];
            acc = clip16(round_div(acc, 32768));
            if (k == 0) p.pitch = 16'(acc);
            else if (k == 1) p.yaw = 16'(acc);
            else p.roll = 16'(acc);
        end
        return p;
    endfunction

    assign pending_poses = expected_poses.size();

    // Capture landmarks and queue a pose on each last transaction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_seen = '0;
            for (int i = 0; i < POSE_POINTS; i++)
            begin
                shape_x[i] = '0;
                shape_y[i] = '0;
            end
        end
        else if (in_valid && !in_stall)
        begin
            if (landmark_index < LANDMARK_COUNT)
                for (int i = 0; i < POSE_POINTS; i++)
                    if (SLOT_INDEX[i] == landmark_index)
                    begin
                        shape_x[i] = coord_x;
                        shape_y[i] = coord_y;
                        shape_seen[i] = 1'b1;
                    end
            if (last)
            begin
                expected_poses.insert(expected_poses.size(), estimate_pose());
                shape_seen = '0;
                for (int i = 0; i < POSE_POINTS; i++)
                begin
                    shape_x[i] = '0;
                    shape_y[i] = '0;
                end
            end
        end
    end

    // Compare each accepted pose with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        pose_t want;
        if (!rst_n)
        begin
            fail_count       <= 0;
            pose_count       <= 0;
            degenerate_count <= 0;
        end
        else if (out_valid && !out_stall)
        begin
            pose_count <= pose_count + 1;
            if (degenerate) degenerate_count <= degenerate_count + 1;
            if (expected_poses.size() == 0)
            begin
                $display("%t: unexpected pose p=%0d y=%0d r=%0d d=%0d",
                         $time, pitch, yaw, roll, degenerate);
                fail_count <= fail_count + 1;
            end
            else
            begin
                want = expected_poses.pop_front();
                if (want.pitch !== pitch || want.yaw !== yaw || want.roll !== roll
                    || want.degenerate !== degenerate)
                begin
                    $display("%t: pose mismatch expected p=%0d y=%0d r=%0d d=%0d",
                             $time, want.pitch, want.yaw, want.roll, want.degenerate);
                    $display("%t:                 actual p=%0d y=%0d r=%0d d=%0d",
                             $time, pitch, yaw, roll, degenerate);
                    fail_count <= fail_count + 1;
                end
            end
        end
    end

endmodule

// File: dv/tb_head_pose_from_landmarks.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_head_pose_from_landmarks : testbench for head_pose_from_landmarks
// Sends directed and random face shapes under several idle and stall
// patterns, including one long output hold-off; a checker predicts poses.
// ----------------------------------------------------------------------------
module tb_head_pose_from_landmarks;

    localparam int POSE_POINTS   = hpl_pkg::POSE_POINTS;

    localparam int PHASE_NONE    = 0;
    localparam int PHASE_SENDER  = 1;
    localparam int PHASE_RECEIVE = 2;
    localparam int PHASE_BOTH    = 3;

    localparam int unsigned KEY_INDEX [POSE_POINTS] = '{27, 29, 33, 31, 65, 46, 52};

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [6:0]         landmark_index;
    logic [15:0]        coord_x;
    logic [15:0]        coord_y;
    logic               last;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic signed [15:0] roll;
    logic               degenerate;

    int fail_count;
    int pending_poses;
    int pose_count;
    int degenerate_count;
    int idle_phase;
    int hold_cycles;
    int landmarks_sent;

    head_pose_from_landmarks i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .landmark_index (landmark_index),
        .coord_x        (coord_x),
        .coord_y        (coord_y),
        .last           (last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pitch          (pitch),
        .yaw            (yaw),
        .roll           (roll),
        .degenerate     (degenerate)
    );

    head_pose_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .landmark_index   (landmark_index),
        .coord_x          (coord_x),
        .coord_y          (coord_y),
        .last             (last),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .pitch            (pitch),
        .yaw              (yaw),
        .roll             (roll),
        .degenerate       (degenerate),
        .fail_count       (fail_count),
        .pending_poses    (pending_poses),
        .pose_count       (pose_count),
        .degenerate_count (degenerate_count)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Stall the output per phase; a long hold-off overrides it.
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall   <= 1'b1;
        end
        else if (idle_phase == PHASE_RECEIVE || idle_phase == PHASE_BOTH)
            out_stall <= ($urandom_range(99) < 68);
        else
            out_stall <= 1'b0;
    end

    // Offer one landmark and hold it until accepted.
    task automatic send_landmark(input logic [6:0] idx, input logic [15:0] x,
                                 input logic [15:0] y, input logic is_last);
        if (idle_phase == PHASE_SENDER || idle_phase == PHASE_BOTH)
            while ($urandom_range(99) < 68)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid       <= 1'b1;
        landmark_index <= idx;
        coord_x        <= x;
        coord_y        <= y;
        last           <= is_last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        landmarks_sent++;
    endtask

    task automatic end_burst();
        in_valid <= 1'b0;
    endtask

    // Send one shape; style 0 is well formed, others sparse or noisy.
    task automatic send_shape(input int style);
        int unsigned cx, cy, spread;
        int n;
        cx = $urandom_range(65535);
        cy = $urandom_range(65535);
        spread = (1 << $urandom_range(15)) - 1;
        if (style == 0)
        begin
            for (int i = 0; i < POSE_POINTS; i++)
                send_landmark(7'(KEY_INDEX[i]), 16'(cx + $urandom_range(spread)),
                              16'(cy + $urandom_range(spread)), 1'b0);
            n = $urandom_range(3);
            for (int i = 0; i < n; i++)
                send_landmark(7'($urandom), 16'($urandom), 16'($urandom), 1'b0);
        end
        else
        begin
            n = $urandom_range(10);
            for (int i = 0; i < n; i++)
                if ($urandom_range(1))
                    send_landmark(7'(KEY_INDEX[$urandom_range(POSE_POINTS-1)]),
                                  16'($urandom), 16'($urandom), 1'b0);
                else
                    send_landmark(7'($urandom), 16'($urandom), 16'($urandom), 1'b0);
        end
        if ($urandom_range(1))
            send_landmark(7'(KEY_INDEX[$urandom_range(POSE_POINTS-1)]),
                          16'(cx + $urandom_range(spread)), 16'(cy + $urandom_range(spread)),
                          1'b1);
        else
            send_landmark(7'($urandom), 16'($urandom), 16'($urandom), 1'b1);
        if ($urandom_range(3) == 0)
        begin
            end_burst();
            @(posedge clk);
        end
    endtask

    // Directed shapes: extremes, empty, zero span, repeats, ignored indices.
    task automatic run_directed();
        send_landmark(7'd0, 16'hFFFF, 16'hFFFF, 1'b1);               // empty shape
        for (int i = 0; i < POSE_POINTS; i++)                       // zero span
            send_landmark(7'(KEY_INDEX[i]), 16'(i * 100), 16'h1234, 1'b0);
        send_landmark(7'd100, 16'hAAAA, 16'h5555, 1'b1);
        send_landmark(7'd27, 16'hFFFF, 16'hFFFF, 1'b0);             // single point extreme
        send_landmark(7'd27, 16'h0000, 16'h0001, 1'b0);             // repeated index
        send_landmark(7'd127, 16'h5555, 16'hAAAA, 1'b0);            // above landmark count
        send_landmark(7'd52, 16'hFFFF, 16'hFFFF, 1'b1);
        for (int i = 0; i < POSE_POINTS; i++)                       // alternating extremes
            send_landmark(7'(KEY_INDEX[i]), (i % 2) ? 16'hFFFF : 16'h0000,
                          (i % 2) ? 16'h0000 : 16'hFFFF, i == POSE_POINTS - 1);
        send_landmark(7'd65, 16'h0001, 16'h0002, 1'b0);             // minimal span
        send_landmark(7'd46, 16'h0000, 16'h0001, 1'b1);
        end_burst();
    endtask

    task automatic drain();
        while (pending_poses != 0)
            @(posedge clk);
        repeat (1000) @(posedge clk);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        out_stall      = 1'b0;
        landmark_index = '0;
        coord_x        = '0;
        coord_y        = '0;
        last           = 1'b0;
        idle_phase     = PHASE_NONE;
        hold_cycles    = 0;
        landmarks_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        for (int phase = PHASE_NONE; phase <= PHASE_BOTH; phase++)
        begin
            idle_phase = phase;
            // Hold the output off long enough that the input backs up.
            if (phase == PHASE_NONE)
                hold_cycles <= 3000;
            while (landmarks_sent < 25 + 450 * (phase + 1))
                send_shape(($urandom_range(9) < 7) ? 0 : 1);
            end_burst();
        end
        idle_phase = PHASE_NONE;
        drain();

        $display("Sent %0d landmarks, checked %0d poses (%0d degenerate).",
                 landmarks_sent, pose_count, degenerate_count);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #40ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: sim.f
src/hpl_pkg.sv
src/hpl_ram.sv
src/hpl_div.sv
src/hpl_seq.sv
src/head_pose_from_landmarks.sv
dv/head_pose_checker.sv
dv/tb_head_pose_from_landmarks.sv
